### design/message_queue_with_priority_waiters_defines.svh
// Assertion macros used by the port-level checks of the message queue block.
`ifndef MESSAGE_QUEUE_WITH_PRIORITY_WAITERS_DEFINES_SVH
`define MESSAGE_QUEUE_WITH_PRIORITY_WAITERS_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define MQPW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mqpw assertion failed");

// Next-cycle implication, disabled while reset is low.
`define MQPW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mqpw assertion failed");

`endif

### design/mqpw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqpw_pkg
// Types, codes and default sizes of the message queue with priority waiters.
// ----------------------------------------------------------------------------
package mqpw_pkg;

	localparam int MsgCountDef = 16;
	localparam int MsgBytesDef = 32;
	localparam int WaitersDef  = 8;

	typedef enum logic [1:0] {
		MODE_SEND   = 2'd0,
		MODE_RECV   = 2'd1,
		MODE_REINIT = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_TOO_LARGE  = 3'd1,
		ST_FULL       = 3'd2,
		ST_EMPTY      = 3'd3,
		ST_WAIT_FULL  = 3'd4,
		ST_BLOCKED    = 3'd5,
		ST_ALREADY    = 3'd6,
		ST_DISCARDED  = 3'd7
	} st_t;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_ACCEPT  = 2'd1,
		PH_DISCARD = 2'd2
	} ph_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_DISCARD,
		OP_SEND_REJECT,
		OP_SEND_BYTE,
		OP_RECV_EMPTY,
		OP_RECV_START,
		OP_RECV_LEN,
		OP_WAKE_INIT_SEND,
		OP_WAKE_INIT_RECV,
		OP_WAKE_RD,
		OP_WAKE_CMP,
		OP_WAKE_LAST,
		OP_WAKE_MOVE,
		OP_EMIT_COMMIT,
		OP_RECV_NOLEN,
		OP_BYTE_RD,
		OP_BYTE_EMIT,
		OP_REINIT,
		OP_BAD
	} dp_op_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] data_byte;
		logic       last_byte;
		logic [7:0] msg_size;
		logic       blocking;
		logic [7:0] task_id;
		logic [7:0] task_priority;
		logic [7:0] buffer_capacity;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       last_result;
		logic [7:0] byte_count;
		logic       woken_valid;
		logic [7:0] woken_task;
		logic [4:0] queue_count;
	} out_item_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       phase_idle;
		logic       phase_discard;
		logic       size_bad;
		logic       full;
		logic       empty;
		logic       last;
		logic       len_zero;
		logic       scan_end;
		logic       list_empty;
		logic       stream_done;
		logic       out_busy;
	} dp_stat_t;

endpackage

### design/mqpw_chan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqpw_chan
// Valid/ready channel carrying one request or result item.
// ----------------------------------------------------------------------------
interface mqpw_chan #(parameter type item_t = logic) ();
	logic  valid;
	logic  ready;
	item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### design/mqpw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqpw_ctrl
// Sequencer: decodes each request and steps the datapath through its work.
// ----------------------------------------------------------------------------
module mqpw_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  mqpw_pkg::dp_stat_t stat,
	output mqpw_pkg::dp_op_t   op
);

	typedef enum logic [3:0] {
		S_IDLE, S_DISP, S_RLEN, S_WINIT, S_WCHK, S_WCMP, S_WMOVE, S_POST,
		S_BEMIT, S_BWAIT, S_WAIT
	} state_t;

	state_t state_q, nxt;
	logic   ret_q, ret_d;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		op    = mqpw_pkg::OP_NONE;
		nxt   = state_q;
		ret_d = ret_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					op  = mqpw_pkg::OP_LOAD;
					nxt = S_DISP;
				end
			end
			S_DISP: begin
				case (stat.mode)
					mqpw_pkg::MODE_SEND: begin
						if (stat.phase_discard) begin
							op  = mqpw_pkg::OP_DISCARD;
							nxt = S_WAIT;
						end else if (stat.phase_idle && (stat.size_bad || stat.full)) begin
							op  = mqpw_pkg::OP_SEND_REJECT;
							nxt = S_WAIT;
						end else begin
							op = mqpw_pkg::OP_SEND_BYTE;
							if (stat.last) begin
								ret_d = 1'b0;
								nxt   = S_WINIT;
							end else begin
								nxt = S_WAIT;
							end
						end
					end
					mqpw_pkg::MODE_RECV: begin
						if (stat.empty) begin
							op  = mqpw_pkg::OP_RECV_EMPTY;
							nxt = S_WAIT;
						end else begin
							op  = mqpw_pkg::OP_RECV_START;
							nxt = S_RLEN;
						end
					end
					mqpw_pkg::MODE_REINIT: begin
						op  = mqpw_pkg::OP_REINIT;
						nxt = S_WAIT;
					end
					default: begin
						op  = mqpw_pkg::OP_BAD;
						nxt = S_WAIT;
					end
				endcase
			end
			S_RLEN: begin
				op    = mqpw_pkg::OP_RECV_LEN;
				ret_d = 1'b1;
				nxt   = S_WINIT;
			end
			S_WINIT: begin
				// a commit wakes a receiver, a receive wakes a sender
				op  = ret_q ? mqpw_pkg::OP_WAKE_INIT_SEND : mqpw_pkg::OP_WAKE_INIT_RECV;
				nxt = S_WCHK;
			end
			S_WCHK: begin
				if (stat.scan_end) begin
					if (stat.list_empty) begin
						nxt = S_POST;
					end else begin
						op  = mqpw_pkg::OP_WAKE_LAST;
						nxt = S_WMOVE;
					end
				end else begin
					op  = mqpw_pkg::OP_WAKE_RD;
					nxt = S_WCMP;
				end
			end
			S_WCMP: begin
				op  = mqpw_pkg::OP_WAKE_CMP;
				nxt = S_WCHK;
			end
			S_WMOVE: begin
				op  = mqpw_pkg::OP_WAKE_MOVE;
				nxt = S_POST;
			end
			S_POST: begin
				if (!ret_q) begin
					op  = mqpw_pkg::OP_EMIT_COMMIT;
					nxt = S_WAIT;
				end else if (stat.len_zero) begin
					op  = mqpw_pkg::OP_RECV_NOLEN;
					nxt = S_WAIT;
				end else begin
					op  = mqpw_pkg::OP_BYTE_RD;
					nxt = S_BEMIT;
				end
			end
			S_BEMIT: begin
				op  = mqpw_pkg::OP_BYTE_EMIT;
				nxt = S_BWAIT;
			end
			S_BWAIT: begin
				if (!stat.out_busy) begin
					if (stat.stream_done) begin
						nxt = S_IDLE;
					end else begin
						op  = mqpw_pkg::OP_BYTE_RD;
						nxt = S_BEMIT;
					end
				end
			end
			S_WAIT: begin
				if (!stat.out_busy) begin
					nxt = S_IDLE;
				end
			end
			default: begin
				nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= 1'b0;
		end else begin
			state_q <= nxt;
			ret_q   <= ret_d;
		end
	end

endmodule

### design/mqpw_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqpw_dp
// Datapath: message ring, length table, wait lists, wake scan, result register.
// ----------------------------------------------------------------------------
module mqpw_dp #(
	parameter int MSG_COUNT = mqpw_pkg::MsgCountDef,
	parameter int MSG_BYTES = mqpw_pkg::MsgBytesDef,
	parameter int WAITERS   = mqpw_pkg::WaitersDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mqpw_pkg::in_item_t  req_data,
	input  mqpw_pkg::dp_op_t    op,
	output mqpw_pkg::dp_stat_t  stat,
	output mqpw_pkg::out_item_t rsp_data,
	output logic                rsp_valid,
	input  logic                rsp_ready
);

	localparam int SW  = $clog2(MSG_COUNT);
	localparam int CW  = $clog2(MSG_COUNT + 1);
	localparam int OCW = $clog2(MSG_BYTES + 1);
	localparam int MD  = MSG_COUNT * MSG_BYTES;
	localparam int AW  = (MD > 1) ? $clog2(MD) : 1;
	localparam int WCW = $clog2(WAITERS + 1);
	localparam int WIW = (WAITERS > 1) ? $clog2(WAITERS) : 1;
	localparam int WD  = 2 * (1 << WIW);

	mqpw_pkg::in_item_t in_q;
	logic [SW-1:0]      head_q, tail_q, slot_q;
	logic [CW-1:0]      cnt_q;
	logic [WCW-1:0]     scnt_q, rcnt_q, wn_q, wi_q;
	logic [OCW-1:0]     off_q, len_q, idx_q, ccnt_q;
	logic [7:0]         lat_q, bprio_q, bid_q, wt_q;
	logic [WIW-1:0]     best_q;
	logic               sel_q, wv_q;
	mqpw_pkg::ph_t      phase_q;

	logic [7:0]     msg_mem [MD];
	logic [OCW-1:0] len_mem [MSG_COUNT];
	logic [15:0]    wait_mem [WD];
	logic [7:0]     msg_rd_q;
	logic [OCW-1:0] len_rd_q;
	logic [15:0]    wait_rd_q;

	logic           is_idle, wr_byte, sfull_w, rfull_w, add_s, add_r, fin;
	logic [OCW-1:0] base_off, new_off, idx_nx;
	logic [7:0]     lim;
	logic [AW-1:0]  msg_wa, msg_ra;
	logic [WIW:0]   wait_wa, wait_ra;
	logic [15:0]    wait_wd;
	logic [4:0]     qc;

	function automatic mqpw_pkg::out_item_t mk_res(input mqpw_pkg::st_t st,
		input logic [7:0] b, input logic bv, input logic lst, input logic [7:0] bc,
		input logic wv, input logic [7:0] wt, input logic [4:0] q);
		mqpw_pkg::out_item_t r;
		r.status      = st;
		r.out_byte    = b;
		r.byte_valid  = bv;
		r.last_result = lst;
		r.byte_count  = bc;
		r.woken_valid = wv;
		r.woken_task  = wt;
		r.queue_count = q;
		return r;
	endfunction

	always_comb begin
		is_idle  = (phase_q == mqpw_pkg::PH_IDLE);
		base_off = is_idle ? '0 : off_q;
		lim      = is_idle ? in_q.msg_size : lat_q;
		wr_byte  = (8'(base_off) < lim) && (base_off < OCW'(MSG_BYTES));
		new_off  = base_off + OCW'(wr_byte);
		sfull_w  = (scnt_q >= WCW'(WAITERS));
		rfull_w  = (rcnt_q >= WCW'(WAITERS));
		add_s    = (op == mqpw_pkg::OP_SEND_REJECT) && (in_q.msg_size <= 8'(MSG_BYTES))
			&& in_q.blocking && !sfull_w;
		add_r    = (op == mqpw_pkg::OP_RECV_EMPTY) && in_q.blocking && !rfull_w;
		msg_wa   = AW'(tail_q) * AW'(MSG_BYTES) + AW'(base_off);
		msg_ra   = AW'(slot_q) * AW'(MSG_BYTES) + AW'(idx_q);
		idx_nx   = idx_q + OCW'(1);
		fin      = (idx_nx == len_q);
		qc       = 5'(cnt_q);
		if (add_s) begin
			wait_wa = {1'b0, WIW'(scnt_q)};
		end else if (add_r) begin
			wait_wa = {1'b1, WIW'(rcnt_q)};
		end else begin
			wait_wa = {sel_q, best_q};
		end
		wait_wd = (add_s || add_r) ? {in_q.task_priority, in_q.task_id} : wait_rd_q;
		// the last entry is fetched before it fills the hole
		wait_ra = (op == mqpw_pkg::OP_WAKE_LAST) ? {sel_q, WIW'(wn_q - WCW'(1))}
			: {sel_q, WIW'(wi_q)};
	end

	always_comb begin
		stat.mode          = in_q.mode;
		stat.phase_idle    = is_idle;
		stat.phase_discard = (phase_q == mqpw_pkg::PH_DISCARD);
		stat.size_bad      = (in_q.msg_size > 8'(MSG_BYTES));
		stat.full          = (cnt_q >= CW'(MSG_COUNT));
		stat.empty         = (cnt_q == '0);
		stat.last          = in_q.last_byte;
		stat.len_zero      = (len_q == '0);
		stat.scan_end      = (wi_q == wn_q);
		stat.list_empty    = (wn_q == '0);
		stat.stream_done   = (idx_q == len_q);
		stat.out_busy      = rsp_valid;
	end

	always_ff @(posedge clk) begin
		if ((op == mqpw_pkg::OP_SEND_BYTE) && wr_byte) begin
			msg_mem[msg_wa] <= in_q.data_byte;
		end
		if ((op == mqpw_pkg::OP_SEND_BYTE) && in_q.last_byte) begin
			len_mem[tail_q] <= new_off;
		end
		if (add_s || add_r || (op == mqpw_pkg::OP_WAKE_MOVE)) begin
			wait_mem[wait_wa] <= wait_wd;
		end
		msg_rd_q  <= msg_mem[msg_ra];
		len_rd_q  <= len_mem[head_q];
		wait_rd_q <= wait_mem[wait_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_q      <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			slot_q    <= '0;
			cnt_q     <= '0;
			scnt_q    <= '0;
			rcnt_q    <= '0;
			wn_q      <= '0;
			wi_q      <= '0;
			off_q     <= '0;
			len_q     <= '0;
			idx_q     <= '0;
			ccnt_q    <= '0;
			lat_q     <= '0;
			bprio_q   <= '0;
			bid_q     <= '0;
			wt_q      <= '0;
			best_q    <= '0;
			sel_q     <= 1'b0;
			wv_q      <= 1'b0;
			phase_q   <= mqpw_pkg::PH_IDLE;
			rsp_valid <= 1'b0;
			rsp_data  <= '0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				rsp_valid <= 1'b0;
			end
			case (op)
				mqpw_pkg::OP_LOAD: begin
					in_q <= req_data;
				end
				mqpw_pkg::OP_DISCARD: begin
					if (in_q.last_byte) begin
						phase_q <= mqpw_pkg::PH_IDLE;
					end
					rsp_valid <= 1'b1;
					rsp_data  <= mk_res(mqpw_pkg::ST_DISCARDED, '0, 1'b0, 1'b1, '0, 1'b0, '0, qc);
				end
				mqpw_pkg::OP_SEND_REJECT: begin
					phase_q   <= in_q.last_byte ? mqpw_pkg::PH_IDLE : mqpw_pkg::PH_DISCARD;
					rsp_valid <= 1'b1;
					if (stat.size_bad) begin
						rsp_data <= mk_res(mqpw_pkg::ST_TOO_LARGE, '0, 1'b0, 1'b1, '0, 1'b0, '0, qc);
					end else if (!in_q.blocking) begin
						rsp_data <= mk_res(mqpw_pkg::ST_FULL, '0, 1'b0, 1'b1, '0, 1'b0, '0, qc);
					end else if (!sfull_w) begin
						scnt_q   <= scnt_q + WCW'(1);
						rsp_data <= mk_res(mqpw_pkg::ST_BLOCKED, '0, 1'b0, 1'b1, '0, 1'b0, '0, qc);
					end else begin
						rsp_data <= mk_res(mqpw_pkg::ST_WAIT_FULL, '0, 1'b0, 1'b1, '0, 1'b0, '0, qc);
					end
				end
				mqpw_pkg::OP_SEND_BYTE: begin
					off_q <= new_off;
					if (is_idle) begin
						lat_q <= in_q.msg_size;
					end
					if (!in_q.last_byte) begin
						phase_q   <= mqpw_pkg::PH_ACCEPT;
						rsp_valid <= 1'b1;
						rsp_data  <= mk_res(mqpw_pkg::ST_OK, '0, 1'b0, 1'b1, 8'(new_off),
							1'b0, '0, qc);
					end else begin
						// commit; the result waits for the wake scan
						phase_q <= mqpw_pkg::PH_IDLE;
						tail_q  <= (tail_q == SW'(MSG_COUNT - 1)) ? '0 : tail_q + SW'(1);
						cnt_q   <= cnt_q + CW'(1);
						ccnt_q  <= new_off;
					end
				end
				mqpw_pkg::OP_RECV_EMPTY: begin
					rsp_valid <= 1'b1;
					if (!in_q.blocking) begin
						rsp_data <= mk_res(mqpw_pkg::ST_EMPTY, '0, 1'b0, 1'b1, '0, 1'b0, '0, qc);
					end else if (!rfull_w) begin
						rcnt_q   <= rcnt_q + WCW'(1);
						rsp_data <= mk_res(mqpw_pkg::ST_BLOCKED, '0, 1'b0, 1'b1, '0, 1'b0, '0, qc);
					end else begin
						rsp_data <= mk_res(mqpw_pkg::ST_WAIT_FULL, '0, 1'b0, 1'b1, '0, 1'b0, '0, qc);
					end
				end
				mqpw_pkg::OP_RECV_START: begin
					slot_q <= head_q;
					head_q <= (head_q == SW'(MSG_COUNT - 1)) ? '0 : head_q + SW'(1);
					cnt_q  <= cnt_q - CW'(1);
				end
				mqpw_pkg::OP_RECV_LEN: begin
					len_q <= (in_q.buffer_capacity < 8'(len_rd_q)) ?
						OCW'(in_q.buffer_capacity) : len_rd_q;
					idx_q <= '0;
				end
				mqpw_pkg::OP_WAKE_INIT_SEND, mqpw_pkg::OP_WAKE_INIT_RECV: begin
					sel_q <= (op == mqpw_pkg::OP_WAKE_INIT_RECV);
					wn_q  <= (op == mqpw_pkg::OP_WAKE_INIT_RECV) ? rcnt_q : scnt_q;
					wi_q  <= '0;
					wv_q  <= 1'b0;
					wt_q  <= '0;
				end
				mqpw_pkg::OP_WAKE_CMP: begin
					// strict compare keeps the first entry of top priority
					if ((wi_q == '0) || (wait_rd_q[15:8] > bprio_q)) begin
						best_q  <= WIW'(wi_q);
						bprio_q <= wait_rd_q[15:8];
						bid_q   <= wait_rd_q[7:0];
					end
					wi_q <= wi_q + WCW'(1);
				end
				mqpw_pkg::OP_WAKE_MOVE: begin
					if (sel_q) begin
						rcnt_q <= wn_q - WCW'(1);
					end else begin
						scnt_q <= wn_q - WCW'(1);
					end
					wv_q <= 1'b1;
					wt_q <= bid_q;
				end
				mqpw_pkg::OP_EMIT_COMMIT: begin
					rsp_valid <= 1'b1;
					rsp_data  <= mk_res(mqpw_pkg::ST_OK, '0, 1'b0, 1'b1, 8'(ccnt_q), wv_q, wt_q, qc);
				end
				mqpw_pkg::OP_RECV_NOLEN: begin
					rsp_valid <= 1'b1;
					rsp_data  <= mk_res(mqpw_pkg::ST_OK, '0, 1'b0, 1'b1, '0, wv_q, wt_q, qc);
				end
				mqpw_pkg::OP_BYTE_EMIT: begin
					rsp_valid <= 1'b1;
					rsp_data  <= mk_res(mqpw_pkg::ST_OK, msg_rd_q, 1'b1, fin, 8'(idx_nx),
						fin && wv_q, fin ? wt_q : 8'd0, qc);
					idx_q     <= idx_nx;
				end
				mqpw_pkg::OP_REINIT: begin
					rsp_valid <= 1'b1;
					if ((cnt_q == '0) && (scnt_q == '0) && (rcnt_q == '0) && is_idle) begin
						head_q   <= '0;
						tail_q   <= '0;
						off_q    <= '0;
						rsp_data <= mk_res(mqpw_pkg::ST_OK, '0, 1'b0, 1'b1, '0, 1'b0, '0, '0);
					end else begin
						rsp_data <= mk_res(mqpw_pkg::ST_ALREADY, '0, 1'b0, 1'b1, '0, 1'b0, '0, qc);
					end
				end
				mqpw_pkg::OP_BAD: begin
					rsp_valid <= 1'b1;
					rsp_data  <= mk_res(mqpw_pkg::ST_DISCARDED, '0, 1'b0, 1'b1, '0, 1'b0, '0, qc);
				end
				default: begin
				end
			endcase
		end
	end

endmodule

### design/message_queue_with_priority_waiters.sv
`timescale 1ns / 1ps
// The block takes one request at a time; the next is taken only after its last result
// is taken. A receive streams its bytes one by one, each further byte only after the
// previous one is taken.
// ----------------------------------------------------------------------------
// message_queue_with_priority_waiters
// Message ring with priority-ordered send and receive wait lists.
// Reset (arst_n low) clears indexes, counts and send phase; memories are not cleared.
// ----------------------------------------------------------------------------
module message_queue_with_priority_waiters #(
	parameter int MSG_COUNT = mqpw_pkg::MsgCountDef,
	parameter int MSG_BYTES = mqpw_pkg::MsgBytesDef,
	parameter int WAITERS   = mqpw_pkg::WaitersDef
) (
	input  logic     clk,
	input  logic     arst_n,
	mqpw_chan.sink   req,
	mqpw_chan.source rsp
);

	mqpw_pkg::dp_op_t   op;
	mqpw_pkg::dp_stat_t stat;

	mqpw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.op        (op)
	);

	mqpw_dp #(
		.MSG_COUNT (MSG_COUNT),
		.MSG_BYTES (MSG_BYTES),
		.WAITERS   (WAITERS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req.data),
		.op        (op),
		.stat      (stat),
		.rsp_data  (rsp.data),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready)
	);

endmodule

### design/mqpw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqpw_props
// Port-level checks of the message queue: request sequencing and result hold.
// ----------------------------------------------------------------------------
`include "message_queue_with_priority_waiters_defines.svh"

module mqpw_props (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic rsp_last
);

	`MQPW_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)
	`MQPW_ASSERT_NXT(a_one_req, clk, arst_n, req_valid && req_ready, !req_ready)
	`MQPW_ASSERT_NXT(a_stream, clk, arst_n, rsp_valid && rsp_ready && !rsp_last, !req_ready)

endmodule

bind message_queue_with_priority_waiters mqpw_props u_mqpw_props (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_last  (rsp.data.last_result)
);

### bench/mqpw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqpw_checker
// Watches the request and result channels of the message queue, keeps its own
// model of the ring and both wait lists, and compares every result in order.
// ----------------------------------------------------------------------------
module mqpw_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_ready,
	input  mqpw_pkg::in_item_t  req_data,
	input  logic                rsp_valid,
	input  logic                rsp_ready,
	input  mqpw_pkg::out_item_t rsp_data,
	output int                  fail_count,
	output int                  pending
);
	localparam int NMSG = mqpw_pkg::MsgCountDef;
	localparam int NBYTES = mqpw_pkg::MsgBytesDef;
	localparam int NWAIT = mqpw_pkg::WaitersDef;

	logic [7:0]          ring_bytes [NMSG*NBYTES];
	logic [5:0]          ring_len [NMSG];
	logic [15:0]         send_waiters [NWAIT];
	logic [15:0]         recv_waiters [NWAIT];
	int                  head, tail, held, n_send_wait, n_recv_wait, wr_off, size_latch;
	mqpw_pkg::ph_t       phase;
	mqpw_pkg::out_item_t expected_results [$];

	assign pending = expected_results.size();

	function automatic mqpw_pkg::out_item_t mk(mqpw_pkg::st_t st, logic [7:0] b, logic bv,
			logic lst, logic [7:0] cnt, logic wv, logic [7:0] wt);
		mqpw_pkg::out_item_t r;
		r.status = st; r.out_byte = b; r.byte_valid = bv; r.last_result = lst;
		r.byte_count = cnt; r.woken_valid = wv; r.woken_task = wt;
		r.queue_count = 5'(held);
		return r;
	endfunction

	// Take the first entry of top priority; move the last entry into its place.
	task automatic wake_top(ref logic [15:0] lst [NWAIT], ref int n, output logic wv,
			output logic [7:0] id);
		int best;
		best = 0; wv = 0; id = 0;
		if (n == 0) return;
		for (int i = 1; i < n; i++)
			if (lst[i][15:8] > lst[best][15:8]) best = i;
		id = lst[best][7:0];
		n--;
		lst[best] = lst[n];
		wv = 1;
	endtask

	task automatic predict_request(mqpw_pkg::in_item_t q);
		logic wv;
		logic [7:0] wt;
		mqpw_pkg::st_t st;
		int slot, len;
		case (q.mode)
			mqpw_pkg::MODE_SEND: begin
				if (phase == mqpw_pkg::PH_DISCARD) begin
					if (q.last_byte) phase = mqpw_pkg::PH_IDLE;
					expected_results.push_back(mk(mqpw_pkg::ST_DISCARDED, 0, 0, 1, 0, 0, 0));
					return;
				end
				if (phase != mqpw_pkg::PH_ACCEPT) begin
					st = mqpw_pkg::ST_OK;
					if (q.msg_size > NBYTES) st = mqpw_pkg::ST_TOO_LARGE;
					else if (held >= NMSG) begin
						if (!q.blocking) st = mqpw_pkg::ST_FULL;
						else if (n_send_wait < NWAIT) begin
							send_waiters[n_send_wait] = {q.task_priority, q.task_id};
							n_send_wait++;
							st = mqpw_pkg::ST_BLOCKED;
						end else st = mqpw_pkg::ST_WAIT_FULL;
					end
					if (st != mqpw_pkg::ST_OK) begin
						phase = q.last_byte ? mqpw_pkg::PH_IDLE : mqpw_pkg::PH_DISCARD;
						expected_results.push_back(mk(st, 0, 0, 1, 0, 0, 0));
						return;
					end
					phase = mqpw_pkg::PH_ACCEPT;
					wr_off = 0;
					size_latch = q.msg_size;
				end
				if (wr_off < size_latch && wr_off < NBYTES) begin
					ring_bytes[tail*NBYTES + wr_off] = q.data_byte;
					wr_off++;
				end
				if (!q.last_byte) begin
					expected_results.push_back(mk(mqpw_pkg::ST_OK, 0, 0, 1, 8'(wr_off), 0, 0));
					return;
				end
				ring_len[tail] = 6'(wr_off);
				tail = (tail + 1) % NMSG;
				held++;
				phase = mqpw_pkg::PH_IDLE;
				wake_top(recv_waiters, n_recv_wait, wv, wt);
				expected_results.push_back(mk(mqpw_pkg::ST_OK, 0, 0, 1, 8'(wr_off), wv, wt));
			end
			mqpw_pkg::MODE_RECV: begin
				if (held == 0) begin
					st = mqpw_pkg::ST_EMPTY;
					if (q.blocking) begin
						if (n_recv_wait < NWAIT) begin
							recv_waiters[n_recv_wait] = {q.task_priority, q.task_id};
							n_recv_wait++;
							st = mqpw_pkg::ST_BLOCKED;
						end else st = mqpw_pkg::ST_WAIT_FULL;
					end
					expected_results.push_back(mk(st, 0, 0, 1, 0, 0, 0));
					return;
				end
				slot = head;
				len = ring_len[slot];
				if (len > NBYTES) len = NBYTES;
				if (q.buffer_capacity < len) len = q.buffer_capacity;
				head = (head + 1) % NMSG;
				held--;
				wake_top(send_waiters, n_send_wait, wv, wt);
				if (len == 0) begin
					expected_results.push_back(mk(mqpw_pkg::ST_OK, 0, 0, 1, 0, wv, wt));
					return;
				end
				for (int i = 0; i < len; i++)
					expected_results.push_back(mk(mqpw_pkg::ST_OK,
						ring_bytes[slot*NBYTES + i], 1, i + 1 == len, 8'(i + 1),
						(i + 1 == len) && wv, (i + 1 == len) ? wt : 8'd0));
			end
			mqpw_pkg::MODE_REINIT: begin
				if (held != 0 || n_send_wait != 0 || n_recv_wait != 0 ||
						phase != mqpw_pkg::PH_IDLE)
					expected_results.push_back(mk(mqpw_pkg::ST_ALREADY, 0, 0, 1, 0, 0, 0));
				else begin
					head = 0; tail = 0; held = 0; n_send_wait = 0; n_recv_wait = 0;
					wr_off = 0;
					expected_results.push_back(mk(mqpw_pkg::ST_OK, 0, 0, 1, 0, 0, 0));
				end
			end
			default: expected_results.push_back(mk(mqpw_pkg::ST_DISCARDED, 0, 0, 1, 0, 0, 0));
		endcase
	endtask

	task automatic check_field(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		mqpw_pkg::out_item_t e;
		if (!arst_n) begin
			head = 0; tail = 0; held = 0; n_send_wait = 0; n_recv_wait = 0;
			wr_off = 0; size_latch = 0; phase = mqpw_pkg::PH_IDLE;
			expected_results.delete();
			fail_count = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_results.size() == 0) begin
					$error("result with no expectation: %h", rsp_data);
					fail_count++;
				end else begin
					e = expected_results.pop_front();
					check_field("status", e.status, rsp_data.status);
					check_field("out_byte", e.out_byte, rsp_data.out_byte);
					check_field("byte_valid", e.byte_valid, rsp_data.byte_valid);
					check_field("last_result", e.last_result, rsp_data.last_result);
					check_field("byte_count", e.byte_count, rsp_data.byte_count);
					check_field("woken_valid", e.woken_valid, rsp_data.woken_valid);
					check_field("woken_task", e.woken_task, rsp_data.woken_task);
					check_field("queue_count", e.queue_count, rsp_data.queue_count);
				end
			end
			if (req_valid && req_ready)
				predict_request(req_data);
		end
	end
endmodule

### bench/tb_message_queue_with_priority_waiters.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_message_queue_with_priority_waiters
// Drives send, receive, reinit and invalid-mode requests into the message queue with random
// idling on both channels, and takes the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_message_queue_with_priority_waiters;

	localparam int WATCHDOG = 20000;
	localparam int LONG_HOLD = 400;

	logic clk = 0;
	logic arst_n = 0;
	int   fail_count, pending;
	int   idle_cycles;
	bit   calm;
	int   hold_off;
	int   long_hold_tok;
	int   long_hold_seen;

	mqpw_chan #(.item_t(mqpw_pkg::in_item_t))  req ();
	mqpw_chan #(.item_t(mqpw_pkg::out_item_t)) rsp ();

	message_queue_with_priority_waiters i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	mqpw_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.req_data  (req.data),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.rsp_data  (rsp.data),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1;
	end

	// Result side: random stall bursts, plus one long hold-off on request.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 0;
			hold_off <= 0;
			long_hold_seen <= 0;
		end else if (long_hold_tok != long_hold_seen) begin
			long_hold_seen <= long_hold_tok;
			hold_off <= LONG_HOLD;
			rsp.ready <= 0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			rsp.ready <= 0;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			hold_off <= $urandom_range(0, 13);
			rsp.ready <= 0;
		end else begin
			rsp.ready <= 1;
		end
	end

	// Watchdog on cycles with no accepted request or result.
	always @(posedge clk) begin
		if (arst_n && !((req.valid && req.ready) || (rsp.valid && rsp.ready))) begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG) begin
				$display("TEST FAILED");
				$finish;
			end
		end else begin
			idle_cycles = 0;
		end
	end

	task automatic send_request(mqpw_pkg::in_item_t q);
		if (!calm && $urandom_range(0, 7) == 0) begin
			req.valid <= 0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		req.valid <= 1;
		req.data <= q;
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic finish_request();
		req.valid <= 0;
	endtask

	function automatic mqpw_pkg::in_item_t rand_fields();
		mqpw_pkg::in_item_t q;
		q.mode = mqpw_pkg::MODE_SEND;
		q.data_byte = 8'($urandom);
		q.last_byte = 1'($urandom);
		q.msg_size = 8'($urandom);
		q.blocking = 1'($urandom);
		q.task_id = 8'($urandom);
		// narrow priorities so that ties occur
		q.task_priority = 8'($urandom_range(0, 7));
		q.buffer_capacity = 8'($urandom);
		return q;
	endfunction

	// One message of n bytes declared as size; random caller fields.
	task automatic send_message(int n, int size, bit blk);
		mqpw_pkg::in_item_t q;
		for (int i = 0; i < n; i++) begin
			q = rand_fields();
			q.msg_size = 8'(size);
			q.last_byte = (i == n - 1);
			q.blocking = blk;
			send_request(q);
		end
	endtask

	task automatic receive(int cap, bit blk);
		mqpw_pkg::in_item_t q;
		q = rand_fields();
		q.mode = mqpw_pkg::MODE_RECV;
		q.buffer_capacity = 8'(cap);
		q.blocking = blk;
		send_request(q);
	endtask

	task automatic plain(logic [1:0] m);
		mqpw_pkg::in_item_t q;
		q = rand_fields();
		q.mode = m;
		send_request(q);
	endtask

	task automatic wait_drain();
		finish_request();
		while (pending != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	initial begin
		int n, sz, pick;
		req.valid <= 0;
		req.data <= '0;
		calm = 0;
		long_hold_tok = 0;
		@(posedge arst_n);
		@(posedge clk);
		// directed
		receive(5, 0);
		receive(5, 1);
		receive(5, 1);
		plain(mqpw_pkg::MODE_REINIT);
		send_message(3, 3, 0);
		send_message(1, 0, 0);
		send_message(5, 2, 0);
		send_message(2, 40, 0);
		send_message(1, 255, 1);
		send_message(32, 32, 0);
		plain(mqpw_pkg::MODE_REINIT);
		plain(2'd3);
		receive(255, 0);
		receive(0, 0);
		receive(1, 0);
		receive(200, 0);
		receive(10, 0);
		receive(3, 0);
		plain(mqpw_pkg::MODE_REINIT);
		// fill the ring with results held back, then overflow with waiters
		finish_request();
		long_hold_tok++;
		for (int i = 0; i < 16; i++) send_message(2, 2, 0);
		send_message(1, 1, 0);
		for (int i = 0; i < 9; i++) send_message(2, 1, 1);
		for (int i = 0; i < 17; i++) receive($urandom_range(0, 4), 0);
		wait_drain();
		// random
		for (int k = 0; k < 100; k++) begin
			if (k == 80) begin
				wait_drain();
				calm = 1;
			end
			pick = $urandom_range(0, 19);
			if (pick < 10) begin
				n = $urandom_range(1, 6);
				sz = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255)
					: ($urandom_range(0, 9) == 0 ? 32 : $urandom_range(0, 7));
				if ($urandom_range(0, 20) == 0) n = 32;
				send_message(n, sz, $urandom_range(0, 1));
			end else if (pick < 18) begin
				receive($urandom_range(0, 9) == 0 ? $urandom_range(0, 255)
					: $urandom_range(0, 8), $urandom_range(0, 1));
			end else if (pick == 18) begin
				plain(mqpw_pkg::MODE_REINIT);
			end else begin
				plain(2'($urandom_range(0, 3)));
			end
		end
		// empty everything, then send and receive one last message
		for (int i = 0; i < 20; i++) receive(2, 0);
		send_message(1, 1, 0);
		receive(1, 0);
		finish_request();
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
